### rtl/hvti_pkg.sv
// Shared types and constants for the HVAC thermostat interlock.
package hvti_pkg;

  // Operating modes.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_COOL = 2'd1;
  localparam logic [1:0] MODE_HEAT = 2'd2;
  localparam logic [1:0] MODE_CIRC = 2'd3;

  // Control sources; any other code forces the mode off.
  localparam logic [1:0] SRC_LOCAL  = 2'd0;
  localparam logic [1:0] SRC_REMOTE = 2'd1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_SP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_DB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_SP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_DB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SRC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY  = 3'd6;

  // On-delay timer presets in ms.
  localparam logic [31:0] PRE_COOL_ON  = 32'd300000;
  localparam logic [31:0] PRE_COOL_OFF = 32'd300000;
  localparam logic [31:0] PRE_HEAT_ON  = 32'd600000;
  localparam logic [31:0] PRE_HEAT_OFF = 32'd600000;
  localparam logic [31:0] PRE_FAN_PRE  = 32'd60000;
  localparam logic [31:0] PRE_FAN_POST = 32'd180000;

  // Minimum on and off times of the guarded outputs in ms.
  localparam logic [31:0] FAN_MIN_ON  = 32'd30000;
  localparam logic [31:0] FAN_MIN_OFF = 32'd30000;
  localparam logic [31:0] SYS_MIN_ON  = 32'd60000;
  localparam logic [31:0] SYS_MIN_OFF = 32'd300000;
  localparam logic [31:0] SEL_MIN_ON  = 32'd300000;
  localparam logic [31:0] SEL_MIN_OFF = 32'd300000;

  // Status of one on-delay timer for the current item.
  typedef struct packed {
    logic active;  // enabled this item
    logic done;    // enabled and preset reached
  } tmr_stat_t;

  // Result of one guarded output for the current item.
  typedef struct packed {
    logic state;    // state before this item
    logic state_d;  // state after this item
    logic refused;  // requested change was blocked
  } guard_res_t;

endpackage

### rtl/hvac_thermostat_interlock.sv
// An accepted item is held in the input register, then processed into the result register when that register is free.
// One item per cycle while results are not stalled; the mode, timer and guarded output update is combinational.
// The result register lets the next item be taken while a result waits to be taken.
// Reset (asynchronous, active low) restores the register defaults, mode off, all guarded outputs off,
// all timers idle with the fan post-run timer done, and all edge times at zero.
module hvac_thermostat_interlock #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned TEMP_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hvti_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [TEMP_BITS-1:0]               cfg_wdata_i,
  // Input item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [TIME_BITS-1:0]               now_ms_i,
  input  logic signed [TEMP_BITS-1:0]        temperature_i,
  input  logic                               temperature_valid_i,
  // Result item channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         current_mode_o,
  output logic                               fan_on_o,
  output logic                               system_on_o,
  output logic                               heat_select_o,
  output logic                               fan_level_o,
  output logic                               system_level_o,
  output logic                               select_level_o,
  output logic                               refused_o,
  output logic                               permissive_fail_o
);

  localparam int unsigned EXT_BITS = TEMP_BITS + 2;

  // Configuration registers
  logic signed [TEMP_BITS-1:0] cool_sp_q;
  logic        [TEMP_BITS-2:0] cool_db_q;
  logic signed [TEMP_BITS-1:0] heat_sp_q;
  logic        [TEMP_BITS-2:0] heat_db_q;
  logic        [1:0]           ctrl_src_q;
  logic        [1:0]           remote_mode_q;
  logic        [2:0]           polarity_q;

  // Input register
  logic                        in_valid_q;
  logic [TIME_BITS-1:0]        now_q;
  logic signed [TEMP_BITS-1:0] temp_q;
  logic                        temp_ok_q;

  // Result register
  logic                        out_valid_q;
  logic [1:0]                  res_mode_q;
  logic                        res_fan_q;
  logic                        res_sys_q;
  logic                        res_sel_q;
  logic [2:0]                  res_level_q;
  logic                        res_refused_q;
  logic                        res_pfail_q;

  logic [1:0]                  mode_q;
  logic [1:0]                  mode_d;
  logic [1:0]                  mode_local;

  logic                        fire;
  logic                        in_accept;

  logic signed [EXT_BITS-1:0]  temp_x;
  logic signed [EXT_BITS-1:0]  cool_hi;
  logic signed [EXT_BITS-1:0]  cool_lo;
  logic signed [EXT_BITS-1:0]  heat_hi;
  logic signed [EXT_BITS-1:0]  heat_lo;
  logic                        pfail;
  logic                        eval_local;

  hvti_pkg::tmr_stat_t         cool_on_st;
  hvti_pkg::tmr_stat_t         cool_off_st;
  hvti_pkg::tmr_stat_t         heat_on_st;
  hvti_pkg::tmr_stat_t         heat_off_st;
  hvti_pkg::tmr_stat_t         fan_pre_st;
  hvti_pkg::tmr_stat_t         fan_post_st;

  hvti_pkg::guard_res_t        fan_res;
  hvti_pkg::guard_res_t        sys_res;
  hvti_pkg::guard_res_t        sel_res;
  logic                        fan_cmd;
  logic                        sys_cmd;
  logic                        sel_eval;

  // Handshake: the input register moves into the result register when it is free.
  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_sp_q     <= TEMP_BITS'(6400);
      cool_db_q     <= (TEMP_BITS-1)'(256);
      heat_sp_q     <= TEMP_BITS'(5120);
      heat_db_q     <= (TEMP_BITS-1)'(256);
      ctrl_src_q    <= hvti_pkg::SRC_LOCAL;
      remote_mode_q <= hvti_pkg::MODE_OFF;
      polarity_q    <= 3'b000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hvti_pkg::CFG_COOL_SP:  cool_sp_q     <= cfg_wdata_i;
        hvti_pkg::CFG_COOL_DB:  cool_db_q     <= cfg_wdata_i[TEMP_BITS-2:0];
        hvti_pkg::CFG_HEAT_SP:  heat_sp_q     <= cfg_wdata_i;
        hvti_pkg::CFG_HEAT_DB:  heat_db_q     <= cfg_wdata_i[TEMP_BITS-2:0];
        hvti_pkg::CFG_CTRL_SRC: ctrl_src_q    <= cfg_wdata_i[1:0];
        hvti_pkg::CFG_REMOTE:   remote_mode_q <= cfg_wdata_i[1:0];
        hvti_pkg::CFG_POLARITY: polarity_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !fire);
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q     <= now_ms_i;
      temp_q    <= temperature_i;
      temp_ok_q <= temperature_valid_i;
    end
  end

  // Band edges and the permissive check, compared exactly at extended width.
  always_comb begin
    temp_x  = EXT_BITS'(temp_q);
    cool_hi = EXT_BITS'(cool_sp_q) + $signed({3'b000, cool_db_q});
    cool_lo = EXT_BITS'(cool_sp_q) - $signed({3'b000, cool_db_q});
    heat_hi = EXT_BITS'(heat_sp_q) + $signed({3'b000, heat_db_q});
    heat_lo = EXT_BITS'(heat_sp_q) - $signed({3'b000, heat_db_q});
    pfail   = !(cool_lo > heat_hi) || !temp_ok_q;
    eval_local = !pfail && (ctrl_src_q == hvti_pkg::SRC_LOCAL);
  end

  // Deadband timers for local control.
  hvti_timer #(.TIME_BITS(TIME_BITS)) u_tmr_cool_on (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_COOL_ON)),
    .eval_i(eval_local), .en_i(temp_x > cool_hi), .commit_i(fire), .stat_o(cool_on_st)
  );
  hvti_timer #(.TIME_BITS(TIME_BITS)) u_tmr_cool_off (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_COOL_OFF)),
    .eval_i(eval_local), .en_i(temp_x < cool_lo), .commit_i(fire), .stat_o(cool_off_st)
  );
  hvti_timer #(.TIME_BITS(TIME_BITS)) u_tmr_heat_on (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_HEAT_ON)),
    .eval_i(eval_local), .en_i(temp_x < heat_lo), .commit_i(fire), .stat_o(heat_on_st)
  );
  hvti_timer #(.TIME_BITS(TIME_BITS)) u_tmr_heat_off (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_HEAT_OFF)),
    .eval_i(eval_local), .en_i(temp_x > heat_hi), .commit_i(fire), .stat_o(heat_off_st)
  );

  // Local mode transitions; circulate behaves as off.
  always_comb begin
    mode_local = mode_q;
    case (mode_q)
      hvti_pkg::MODE_OFF, hvti_pkg::MODE_CIRC: begin
        if (cool_on_st.done) begin
          mode_local = hvti_pkg::MODE_COOL;
        end else if (heat_on_st.done) begin
          mode_local = hvti_pkg::MODE_HEAT;
        end else begin
          mode_local = hvti_pkg::MODE_OFF;
        end
      end
      hvti_pkg::MODE_COOL: begin
        if (cool_off_st.done) begin
          mode_local = hvti_pkg::MODE_OFF;
        end
      end
      default: begin
        if (heat_off_st.done) begin
          mode_local = hvti_pkg::MODE_OFF;
        end
      end
    endcase
  end

  // Mode after this item.
  always_comb begin
    if (pfail) begin
      mode_d = hvti_pkg::MODE_OFF;
    end else begin
      case (ctrl_src_q)
        hvti_pkg::SRC_LOCAL:  mode_d = mode_local;
        hvti_pkg::SRC_REMOTE: mode_d = remote_mode_q;
        default:              mode_d = hvti_pkg::MODE_OFF;
      endcase
    end
  end

  // Fan pre-run and post-run timers; post-run is done out of reset.
  hvti_timer #(.TIME_BITS(TIME_BITS)) u_tmr_fan_pre (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_FAN_PRE)),
    .eval_i(!pfail), .en_i(mode_d != hvti_pkg::MODE_OFF), .commit_i(fire),
    .stat_o(fan_pre_st)
  );
  hvti_timer #(.TIME_BITS(TIME_BITS), .DoneReset(1'b1)) u_tmr_fan_post (
    .clk_i, .rst_ni, .now_i(now_q),
    .preset_i(TIME_BITS'(hvti_pkg::PRE_FAN_POST)),
    .eval_i(!pfail), .en_i(mode_d == hvti_pkg::MODE_OFF), .commit_i(fire),
    .stat_o(fan_post_st)
  );

  // Output commands; a failed permissive drops fan and system.
  always_comb begin
    fan_cmd = !pfail && (fan_pre_st.active || (fan_post_st.active && !fan_post_st.done));
    sys_cmd = !pfail && ((mode_d == hvti_pkg::MODE_COOL) || (mode_d == hvti_pkg::MODE_HEAT))
              && fan_pre_st.done;
  end

  hvti_guard #(.TIME_BITS(TIME_BITS)) u_guard_fan (
    .clk_i, .rst_ni, .now_i(now_q),
    .min_on_i(TIME_BITS'(hvti_pkg::FAN_MIN_ON)),
    .min_off_i(TIME_BITS'(hvti_pkg::FAN_MIN_OFF)),
    .eval_i(1'b1), .cmd_i(fan_cmd), .commit_i(fire), .res_o(fan_res)
  );
  hvti_guard #(.TIME_BITS(TIME_BITS)) u_guard_sys (
    .clk_i, .rst_ni, .now_i(now_q),
    .min_on_i(TIME_BITS'(hvti_pkg::SYS_MIN_ON)),
    .min_off_i(TIME_BITS'(hvti_pkg::SYS_MIN_OFF)),
    .eval_i(1'b1), .cmd_i(sys_cmd), .commit_i(fire), .res_o(sys_res)
  );

  // The changeover moves only while the system is off after its own update.
  assign sel_eval = !pfail && !sys_res.state_d;

  hvti_guard #(.TIME_BITS(TIME_BITS)) u_guard_sel (
    .clk_i, .rst_ni, .now_i(now_q),
    .min_on_i(TIME_BITS'(hvti_pkg::SEL_MIN_ON)),
    .min_off_i(TIME_BITS'(hvti_pkg::SEL_MIN_OFF)),
    .eval_i(sel_eval), .cmd_i(mode_d == hvti_pkg::MODE_HEAT), .commit_i(fire),
    .res_o(sel_res)
  );

  // Mode register and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hvti_pkg::MODE_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mode_q    <= mode_d;
      res_fan_q     <= fan_res.state_d;
      res_sys_q     <= sys_res.state_d;
      res_sel_q     <= sel_res.state_d;
      res_level_q   <= {sel_res.state_d, sys_res.state_d, fan_res.state_d} ^ polarity_q;
      res_refused_q <= fan_res.refused || sys_res.refused || sel_res.refused;
      res_pfail_q   <= pfail;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_mode_o    = res_mode_q;
  assign fan_on_o          = res_fan_q;
  assign system_on_o       = res_sys_q;
  assign heat_select_o     = res_sel_q;
  assign fan_level_o       = res_level_q[0];
  assign system_level_o    = res_level_q[1];
  assign select_level_o    = res_level_q[2];
  assign refused_o         = res_refused_q;
  assign permissive_fail_o = res_pfail_q;

  // A failed permissive always reports the mode as off.
  a_pfail_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && permissive_fail_o |-> current_mode_o == hvti_pkg::MODE_OFF)
    else $error("permissive failure reported with mode not off");

  // The changeover never moves while the system output is on.
  a_sel_sys_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (sel_res.state_d != sel_res.state) |-> !sys_res.state_d)
    else $error("changeover moved with system on");

  // A processed item always produces a result.
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed item produced no result");

  // A held item stays in the input register until processed.
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q)
    else $error("held item lost");

endmodule

### rtl/hvti_timer.sv
// On-delay timer with latched done flag and modular elapsed time.
module hvti_timer #(
  parameter int unsigned TIME_BITS = 40,
  parameter logic        DoneReset = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic [TIME_BITS-1:0]  preset_i,
  input  logic                  eval_i,
  input  logic                  en_i,
  input  logic                  commit_i,
  output hvti_pkg::tmr_stat_t   stat_o
);

  logic                 running_q;
  logic [TIME_BITS-1:0] start_q;
  logic                 done_q;
  logic [TIME_BITS-1:0] elapsed;
  logic                 done_d;

  // A timer that starts on this item has zero elapsed time.
  always_comb begin
    elapsed = running_q ? (now_i - start_q) : '0;
    done_d  = done_q | (elapsed >= preset_i);
    stat_o.active = en_i;
    stat_o.done   = en_i & done_d;
  end

  // State moves only when the item is committed and this timer is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      start_q   <= '0;
      done_q    <= DoneReset;
    end else if (commit_i && eval_i) begin
      if (en_i) begin
        running_q <= 1'b1;
        if (!running_q) begin
          start_q <= now_i;
        end
        done_q <= done_d;
      end else begin
        running_q <= 1'b0;
        done_q    <= 1'b0;
      end
    end
  end

endmodule

### rtl/hvti_guard.sv
// Guarded output with minimum on and off times.
module hvti_guard #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic [TIME_BITS-1:0]  min_on_i,
  input  logic [TIME_BITS-1:0]  min_off_i,
  input  logic                  eval_i,
  input  logic                  cmd_i,
  input  logic                  commit_i,
  output hvti_pkg::guard_res_t  res_o
);

  logic                 state_q;
  logic [TIME_BITS-1:0] on_time_q;
  logic [TIME_BITS-1:0] off_time_q;
  logic                 change;
  logic                 blocked;

  // A change is blocked while the time since the opposite edge is too short.
  always_comb begin
    change  = eval_i && (cmd_i != state_q);
    blocked = cmd_i ? ((now_i - off_time_q) < min_off_i)
                    : ((now_i - on_time_q) < min_on_i);
    res_o.state   = state_q;
    res_o.refused = change && blocked;
    res_o.state_d = (change && !blocked) ? cmd_i : state_q;
  end

  // Record the time of each accepted edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= 1'b0;
      on_time_q  <= '0;
      off_time_q <= '0;
    end else if (commit_i && change && !blocked) begin
      state_q <= cmd_i;
      if (cmd_i) begin
        on_time_q <= now_i;
      end else begin
        off_time_q <= now_i;
      end
    end
  end

endmodule
